@@ design/timed_dual_wheel_motor_command_unit_macros.svh @@
// assertion helpers, sampled on clk and quiet during reset
`ifndef TIMED_DUAL_WHEEL_MOTOR_COMMAND_UNIT_MACROS_SVH
`define TIMED_DUAL_WHEEL_MOTOR_COMMAND_UNIT_MACROS_SVH

`define TDWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define TDWM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ design/tdwm_pkg.sv @@
package tdwm_pkg;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned DIR_W  = 3;
  localparam int unsigned SPD_W  = 8;
  localparam int unsigned DURQ_W = 32;
  localparam int unsigned MS_W   = 20;
  localparam int unsigned CFGI_W = 3;
  localparam int unsigned CFGD_W = 20;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 48;

  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_IDLE  = 2'd3;

  localparam logic [DIR_W-1:0] DIR_STOP     = 3'd0;
  localparam logic [DIR_W-1:0] DIR_FORWARD  = 3'd1;
  localparam logic [DIR_W-1:0] DIR_BACKWARD = 3'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT     = 3'd3;
  localparam logic [DIR_W-1:0] DIR_RIGHT    = 3'd4;

  localparam logic [CFGI_W-1:0] REG_DRIVER_ENABLE    = 3'd0;
  localparam logic [CFGI_W-1:0] REG_SPEED_FLOOR      = 3'd1;
  localparam logic [CFGI_W-1:0] REG_SPEED_CEILING    = 3'd2;
  localparam logic [CFGI_W-1:0] REG_DEFAULT_DURATION = 3'd3;
  localparam logic [CFGI_W-1:0] REG_WATCHDOG_CAP     = 3'd4;

  localparam logic [SPD_W-1:0] RST_SPEED_CEILING    = 8'd255;
  localparam logic [MS_W-1:0]  RST_DEFAULT_DURATION = 20'd200;
  localparam logic [MS_W-1:0]  RST_WATCHDOG_CAP     = 20'd5000;

  typedef struct packed {
    logic             driver_enable;
    logic [SPD_W-1:0] speed_floor;
    logic [SPD_W-1:0] speed_ceiling;
    logic [MS_W-1:0]  default_duration;
    logic [MS_W-1:0]  watchdog_cap;
  } cfg_t;

  typedef struct packed {
    logic [DURQ_W-1:0] duration_request;
    logic [SPD_W-1:0]  speed_request;
    logic [DIR_W-1:0]  direction;
    logic [CMD_W-1:0]  command;
  } in_item_t;

  typedef struct packed {
    logic             auto_stopped;
    logic             start_accepted;
    logic [MS_W-1:0]  remaining_ms;
    logic [DIR_W-1:0] motion;
    logic [SPD_W-1:0] right_duty;
    logic             right_in_two;
    logic             right_in_one;
    logic [SPD_W-1:0] left_duty;
    logic             left_in_two;
    logic             left_in_one;
  } out_item_t;

endpackage

@@ design/tdwm_cfg.sv @@
module tdwm_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        we,
  input  logic [tdwm_pkg::CFGI_W-1:0] index,
  input  logic [tdwm_pkg::CFGD_W-1:0] wdata,
  output tdwm_pkg::cfg_t              cfg
);

  tdwm_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.driver_enable    <= 1'b0;
      cfg_r.speed_floor      <= '0;
      cfg_r.speed_ceiling    <= tdwm_pkg::RST_SPEED_CEILING;
      cfg_r.default_duration <= tdwm_pkg::RST_DEFAULT_DURATION;
      cfg_r.watchdog_cap     <= tdwm_pkg::RST_WATCHDOG_CAP;
    end else if (we) begin
      unique case (index)
        tdwm_pkg::REG_DRIVER_ENABLE:    cfg_r.driver_enable    <= wdata[0];
        tdwm_pkg::REG_SPEED_FLOOR:      cfg_r.speed_floor      <= wdata[tdwm_pkg::SPD_W-1:0];
        tdwm_pkg::REG_SPEED_CEILING:    cfg_r.speed_ceiling    <= wdata[tdwm_pkg::SPD_W-1:0];
        tdwm_pkg::REG_DEFAULT_DURATION: cfg_r.default_duration <= wdata[tdwm_pkg::MS_W-1:0];
        tdwm_pkg::REG_WATCHDOG_CAP:     cfg_r.watchdog_cap     <= wdata[tdwm_pkg::MS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ design/tdwm_core.sv @@
module tdwm_core (
  input  logic                clk,
  input  logic                rst_n,
  input  tdwm_pkg::cfg_t      cfg,
  input  tdwm_pkg::in_item_t  item,
  input  logic                step,
  output tdwm_pkg::out_item_t res
);

  logic [tdwm_pkg::DIR_W-1:0] dir_r, dir_nxt;
  logic [tdwm_pkg::SPD_W-1:0] spd_r, spd_nxt;
  logic [tdwm_pkg::MS_W-1:0]  tl_r, tl_nxt;

  logic                        dir_ok;
  logic [tdwm_pkg::SPD_W-1:0]  spd_clamp;
  logic [tdwm_pkg::DURQ_W-1:0] dur_pick;
  logic [tdwm_pkg::MS_W-1:0]   dur_cap;
  logic [tdwm_pkg::MS_W-1:0]   tl_dec;
  logic                        accepted;
  logic                        autostop;

  assign dir_ok = (item.direction == tdwm_pkg::DIR_FORWARD)  ||
                  (item.direction == tdwm_pkg::DIR_BACKWARD) ||
                  (item.direction == tdwm_pkg::DIR_LEFT)     ||
                  (item.direction == tdwm_pkg::DIR_RIGHT);

  always_comb begin
    priority if (item.speed_request < cfg.speed_floor) spd_clamp = cfg.speed_floor;
    else if (item.speed_request > cfg.speed_ceiling)   spd_clamp = cfg.speed_ceiling;
    else                                               spd_clamp = item.speed_request;
  end

  always_comb begin
    dur_pick = (item.duration_request == '0)
             ? {{(tdwm_pkg::DURQ_W-tdwm_pkg::MS_W){1'b0}}, cfg.default_duration}
             : item.duration_request;
    dur_cap  = (dur_pick > {{(tdwm_pkg::DURQ_W-tdwm_pkg::MS_W){1'b0}}, cfg.watchdog_cap})
             ? cfg.watchdog_cap : dur_pick[tdwm_pkg::MS_W-1:0];
  end

  assign tl_dec = (tl_r != '0) ? tl_r - 1'b1 : '0;

  always_comb begin
    dir_nxt  = dir_r;
    spd_nxt  = spd_r;
    tl_nxt   = tl_r;
    accepted = 1'b0;
    autostop = 1'b0;
    unique case (item.command)
      tdwm_pkg::CMD_TICK: begin
        if (dir_r != tdwm_pkg::DIR_STOP) begin
          tl_nxt = tl_dec;
          if (tl_dec == '0) begin
            dir_nxt  = tdwm_pkg::DIR_STOP;
            spd_nxt  = '0;
            autostop = 1'b1;
          end
        end
      end
      tdwm_pkg::CMD_START: begin
        if (cfg.driver_enable && dir_ok) begin
          dir_nxt  = item.direction;
          spd_nxt  = spd_clamp;
          tl_nxt   = dur_cap;
          accepted = 1'b1;
        end else begin
          dir_nxt = tdwm_pkg::DIR_STOP;
          spd_nxt = '0;
          tl_nxt  = '0;
        end
      end
      tdwm_pkg::CMD_STOP: begin
        dir_nxt = tdwm_pkg::DIR_STOP;
        spd_nxt = '0;
        tl_nxt  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= tdwm_pkg::DIR_STOP;
      spd_r <= '0;
      tl_r  <= '0;
    end else if (step) begin
      dir_r <= dir_nxt;
      spd_r <= spd_nxt;
      tl_r  <= tl_nxt;
    end
  end

  // bridge levels: forward is one/zero, backward zero/one, brake both high
  always_comb begin
    res.left_in_one  = 1'b1;
    res.left_in_two  = 1'b1;
    res.left_duty    = '0;
    res.right_in_one = 1'b1;
    res.right_in_two = 1'b1;
    res.right_duty   = '0;
    unique case (dir_nxt)
      tdwm_pkg::DIR_FORWARD: begin
        res.left_in_two  = 1'b0;
        res.right_in_two = 1'b0;
        res.left_duty    = spd_nxt;
        res.right_duty   = spd_nxt;
      end
      tdwm_pkg::DIR_BACKWARD: begin
        res.left_in_one  = 1'b0;
        res.right_in_one = 1'b0;
        res.left_duty    = spd_nxt;
        res.right_duty   = spd_nxt;
      end
      tdwm_pkg::DIR_LEFT: begin
        res.left_in_one  = 1'b0;
        res.right_in_two = 1'b0;
        res.left_duty    = spd_nxt;
        res.right_duty   = spd_nxt;
      end
      tdwm_pkg::DIR_RIGHT: begin
        res.left_in_two  = 1'b0;
        res.right_in_one = 1'b0;
        res.left_duty    = spd_nxt;
        res.right_duty   = spd_nxt;
      end
      default: ;
    endcase
    res.motion         = dir_nxt;
    res.remaining_ms   = (dir_nxt != tdwm_pkg::DIR_STOP) ? tl_nxt : '0;
    res.start_accepted = accepted;
    res.auto_stopped   = autostop;
  end

endmodule

@@ design/timed_dual_wheel_motor_command_unit.sv @@
// a beat accepted into the input register moves on through the core into the output
// register once that register is free or being read, and is then offered on out_
// throughput: one beat per cycle while out_tready is high; with a result waiting and
// out_tready low one more beat is taken, then in_tready falls until the result leaves
// reset (rst_n low, synchronous): pipeline empty, motion stopped with brake,
// registers back to their defaults
module timed_dual_wheel_motor_command_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tdwm_pkg::CFGI_W-1:0]      cfg_index,
  input  logic [tdwm_pkg::CFGD_W-1:0]      cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // direction[2:0], speed_request[10:3], duration_request[42:11], zero fill
  input  logic [tdwm_pkg::IN_TDATA_W-1:0]  in_tdata,
  // command[1:0]
  input  logic [tdwm_pkg::CMD_W-1:0]       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // left_in_one, left_in_two, left_duty, right_in_one, right_in_two, right_duty,
  // motion, remaining_ms, start_accepted, auto_stopped, zero fill
  output logic [tdwm_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int unsigned ItemW = $bits(tdwm_pkg::out_item_t);

  tdwm_pkg::cfg_t      cfg;
  tdwm_pkg::in_item_t  in_item_r;
  tdwm_pkg::out_item_t res;
  tdwm_pkg::out_item_t out_item_r;
  logic                in_valid_r;
  logic                out_valid_r;
  logic                advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r.command          <= in_tuser;
      in_item_r.direction        <= in_tdata[2:0];
      in_item_r.speed_request    <= in_tdata[10:3];
      in_item_r.duration_request <= in_tdata[42:11];
    end
  end

  tdwm_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  tdwm_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .item  (in_item_r),
    .step  (advance),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(tdwm_pkg::OUT_TDATA_W-ItemW){1'b0}}, out_item_r};

  `include "timed_dual_wheel_motor_command_unit_macros.svh"

  `TDWM_ASSERT(a_brake_when_stopped, (out_valid_r && out_item_r.motion == tdwm_pkg::DIR_STOP) |-> (out_item_r.remaining_ms == '0 && out_item_r.left_duty == '0 && out_item_r.right_duty == '0 && out_item_r.left_in_one && out_item_r.left_in_two && out_item_r.right_in_one && out_item_r.right_in_two), "stopped result without short brake")
  `TDWM_ASSERT(a_start_moves, (out_valid_r && out_item_r.start_accepted) |-> (out_item_r.motion != tdwm_pkg::DIR_STOP && !out_item_r.auto_stopped), "accepted start left the block stopped")
  `TDWM_ASSERT(a_autostop_stops, (out_valid_r && out_item_r.auto_stopped) |-> (out_item_r.motion == tdwm_pkg::DIR_STOP), "auto stop with motion still set")
  `TDWM_ASSERT_NEXT(a_held_item_kept, in_valid_r && !advance, in_valid_r && $stable(in_item_r), "held input beat lost or changed")
  `TDWM_ASSERT_NEXT(a_result_after_step, advance, out_valid_r, "stepped beat produced no result")

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import tdwm_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFGI_W-1:0]      cfg_index = '0;
  logic [CFGD_W-1:0]      cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // direction, speed_request, duration_request, zero fill
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  // command
  logic [CMD_W-1:0]       in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // left_in_one, left_in_two, left_duty, right_in_one, right_in_two, right_duty,
  // motion, remaining_ms, start_accepted, auto_stopped, zero fill
  logic [OUT_TDATA_W-1:0] out_tdata;

  timed_dual_wheel_motor_command_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  // register copy and motion state of the predictor
  cfg_t             regs_now = '{driver_enable: 1'b0, speed_floor: '0,
                                 speed_ceiling: RST_SPEED_CEILING,
                                 default_duration: RST_DEFAULT_DURATION,
                                 watchdog_cap: RST_WATCHDOG_CAP};
  logic [DIR_W-1:0] mot_dir = DIR_STOP;
  logic [SPD_W-1:0] mot_speed = '0;
  logic [MS_W-1:0]  mot_left = '0;

  in_item_t    pending[$];
  out_item_t   status_due[$];
  in_item_t    drv_item;
  in_item_t    seen_in;
  out_item_t   got, want;
  logic        in_taken = 1'b0;
  bit          gaps_on = 1'b1;
  int unsigned wr_gap = 0;
  int unsigned rd_stall = 0;
  int unsigned n_errors = 0;
  int unsigned n_checked = 0;
  int unsigned n_started = 0;
  int unsigned n_autostops = 0;
  int unsigned n_settings = 0;

  function automatic out_item_t motor_step(input in_item_t cmd_in);
    out_item_t        r;
    logic [SPD_W-1:0] spd;
    logic [31:0]      dur;
    logic             lf, rf;
    spd = cmd_in.speed_request;
    dur = cmd_in.duration_request;
    r = '0;
    case (cmd_in.command)
      CMD_TICK: begin
        if (mot_dir != DIR_STOP) begin
          if (mot_left != 0) mot_left = mot_left - 1'b1;
          if (mot_left == 0) begin
            mot_dir = DIR_STOP;
            mot_speed = '0;
            r.auto_stopped = 1'b1;
          end
        end
      end
      CMD_START: begin
        if (!regs_now.driver_enable || cmd_in.direction == DIR_STOP ||
            cmd_in.direction > DIR_RIGHT) begin
          mot_dir = DIR_STOP;
          mot_speed = '0;
          mot_left = '0;
        end else begin
          if (spd < regs_now.speed_floor) spd = regs_now.speed_floor;
          else if (spd > regs_now.speed_ceiling) spd = regs_now.speed_ceiling;
          if (dur == 0) dur = {12'b0, regs_now.default_duration};
          if (dur > {12'b0, regs_now.watchdog_cap}) dur = {12'b0, regs_now.watchdog_cap};
          mot_dir = cmd_in.direction;
          mot_speed = spd;
          mot_left = dur[MS_W-1:0];
          r.start_accepted = 1'b1;
        end
      end
      CMD_STOP: begin
        mot_dir = DIR_STOP;
        mot_speed = '0;
        mot_left = '0;
      end
      default: ;
    endcase
    lf = (mot_dir == DIR_FORWARD || mot_dir == DIR_RIGHT);
    rf = (mot_dir == DIR_FORWARD || mot_dir == DIR_LEFT);
    if (mot_dir == DIR_STOP) begin
      r.left_in_one = 1'b1;
      r.left_in_two = 1'b1;
      r.right_in_one = 1'b1;
      r.right_in_two = 1'b1;
    end else begin
      r.left_in_one = lf;
      r.left_in_two = !lf;
      r.left_duty = mot_speed;
      r.right_in_one = rf;
      r.right_in_two = !rf;
      r.right_duty = mot_speed;
      r.remaining_ms = mot_left;
    end
    r.motion = mot_dir;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      n_errors++;
    end
  endtask

  // input side
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
    end else if (wr_gap != 0) begin
      wr_gap = wr_gap - 1;
      in_tvalid <= 1'b0;
    end else if (pending.size() != 0) begin
      drv_item = pending.pop_front();
      in_tdata <= {5'b0, drv_item.duration_request, drv_item.speed_request,
                   drv_item.direction};
      in_tuser <= drv_item.command;
      in_tvalid <= 1'b1;
      wr_gap = gaps_on ? pick_gap() : 0;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (!gaps_on) begin
      rd_stall = 0;
      out_tready <= 1'b1;
    end else if (rd_stall != 0) begin
      rd_stall = rd_stall - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      rd_stall = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
    end
  end

  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        seen_in.command = in_tuser;
        seen_in.direction = in_tdata[2:0];
        seen_in.speed_request = in_tdata[10:3];
        seen_in.duration_request = in_tdata[42:11];
        status_due.push_back(motor_step(seen_in));
      end
      if (out_tvalid && out_tready) begin
        got = out_item_t'(out_tdata[$bits(out_item_t)-1:0]);
        if (status_due.size() == 0) begin
          $error("result beat with no command pending");
          n_errors++;
        end else begin
          want = status_due.pop_front();
          n_checked++;
          if (want.start_accepted) n_started++;
          if (want.auto_stopped) n_autostops++;
          check_field("left_in_one", 32'(want.left_in_one), 32'(got.left_in_one));
          check_field("left_in_two", 32'(want.left_in_two), 32'(got.left_in_two));
          check_field("left_duty", 32'(want.left_duty), 32'(got.left_duty));
          check_field("right_in_one", 32'(want.right_in_one), 32'(got.right_in_one));
          check_field("right_in_two", 32'(want.right_in_two), 32'(got.right_in_two));
          check_field("right_duty", 32'(want.right_duty), 32'(got.right_duty));
          check_field("motion", 32'(want.motion), 32'(got.motion));
          check_field("remaining_ms", 32'(want.remaining_ms), 32'(got.remaining_ms));
          check_field("start_accepted", 32'(want.start_accepted),
                      32'(got.start_accepted));
          check_field("auto_stopped", 32'(want.auto_stopped), 32'(got.auto_stopped));
        end
      end
    end
  end

  task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [DIR_W-1:0] dir,
                           input logic [SPD_W-1:0] spd, input logic [31:0] dur);
    in_item_t t;
    t.command = cmd;
    t.direction = dir;
    t.speed_request = spd;
    t.duration_request = dur;
    pending.push_back(t);
  endtask

  task automatic write_reg(input logic [CFGI_W-1:0] idx, input logic [CFGD_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DRIVER_ENABLE:    regs_now.driver_enable = val[0];
      REG_SPEED_FLOOR:      regs_now.speed_floor = val[SPD_W-1:0];
      REG_SPEED_CEILING:    regs_now.speed_ceiling = val[SPD_W-1:0];
      REG_DEFAULT_DURATION: regs_now.default_duration = val;
      REG_WATCHDOG_CAP:     regs_now.watchdog_cap = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic en, input logic [SPD_W-1:0] fl,
                                input logic [SPD_W-1:0] ce, input logic [MS_W-1:0] dd,
                                input logic [MS_W-1:0] cap);
    write_reg(REG_DRIVER_ENABLE, {19'b0, en});
    write_reg(REG_SPEED_FLOOR, {12'b0, fl});
    write_reg(REG_SPEED_CEILING, {12'b0, ce});
    write_reg(REG_DEFAULT_DURATION, dd);
    write_reg(REG_WATCHDOG_CAP, cap);
    n_settings++;
  endtask

  // wait until every beat is sent and every status has come back
  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pending.size() != 0 || in_tvalid || status_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // mostly start-and-count-down runs with random content, some noise
  task automatic random_run(input int unsigned n);
    int unsigned made, k, q;
    logic [31:0] d;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 99) < 80) begin
        q = $urandom_range(0, 9);
        d = (q == 0) ? 32'd0 : (q == 1) ? $urandom : $urandom_range(1, 40);
        push_item(CMD_START, DIR_W'($urandom_range(DIR_FORWARD, DIR_RIGHT)),
                  SPD_W'($urandom), d);
        k = $urandom_range(0, 45);
        made += k + 1;
        repeat (k) push_item(CMD_TICK, DIR_W'($urandom), SPD_W'($urandom), $urandom);
        q = $urandom_range(0, 9);
        if (q < 2) begin
          push_item(CMD_STOP, DIR_W'($urandom), SPD_W'($urandom), $urandom);
          made++;
        end else if (q == 2) begin
          push_item(CMD_IDLE, DIR_W'($urandom), SPD_W'($urandom), $urandom);
        end
      end else begin
        q = $urandom_range(0, 3);
        push_item(CMD_W'(q), DIR_W'($urandom), SPD_W'($urandom), $urandom);
        if (q != CMD_IDLE) made++;
      end
    end
  endtask

  initial begin
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // driver still disabled after reset
    push_item(CMD_START, DIR_FORWARD, 8'd128, 32'd10);
    push_item(CMD_TICK, DIR_STOP, 8'd0, 32'd0);
    push_item(CMD_IDLE, DIR_RIGHT, 8'd255, 32'hFFFF_FFFF);
    drain();

    apply_settings(1'b1, 8'd0, 8'd255, 20'd200, 20'd5000);
    push_item(CMD_START, DIR_FORWARD, 8'd0, 32'd0);
    push_item(CMD_IDLE, DIR_STOP, 8'd0, 32'd0);
    push_item(CMD_START, DIR_BACKWARD, 8'd255, 32'hFFFF_FFFF);
    push_item(CMD_TICK, DIR_STOP, 8'd0, 32'd0);
    push_item(CMD_START, DIR_LEFT, 8'd77, 32'd2);
    push_item(CMD_TICK, DIR_STOP, 8'd0, 32'd0);
    push_item(CMD_TICK, DIR_STOP, 8'd0, 32'd0);
    push_item(CMD_TICK, DIR_STOP, 8'd0, 32'd0);
    push_item(CMD_START, DIR_RIGHT, 8'd5, 32'd100);
    push_item(CMD_STOP, 3'd7, 8'd255, 32'hFFFF_FFFF);
    push_item(CMD_START, DIR_STOP, 8'd50, 32'd50);
    push_item(CMD_START, 3'd5, 8'd50, 32'd50);
    push_item(CMD_START, 3'd6, 8'd50, 32'd50);
    push_item(CMD_START, 3'd7, 8'd50, 32'd50);
    drain();

    // floor above ceiling, default above cap
    apply_settings(1'b1, 8'd200, 8'd50, 20'hFFFFF, 20'd3);
    push_item(CMD_START, DIR_FORWARD, 8'd10, 32'd0);
    push_item(CMD_START, DIR_LEFT, 8'd255, 32'd0);
    repeat (3) push_item(CMD_TICK, DIR_STOP, 8'd0, 32'd0);
    drain();

    // zero duration once limits apply
    apply_settings(1'b1, 8'd0, 8'd255, 20'd0, 20'd0);
    push_item(CMD_START, DIR_RIGHT, 8'd9, 32'd0);
    push_item(CMD_TICK, DIR_STOP, 8'd0, 32'd0);
    push_item(CMD_START, DIR_FORWARD, 8'd9, 32'd1234);
    push_item(CMD_TICK, DIR_STOP, 8'd0, 32'd0);
    drain();

    gaps_on = 1'b0;
    apply_settings(1'b1, 8'd0, 8'd255, 20'd20, 20'd30);
    random_run(270);
    drain();
    gaps_on = 1'b1;
    apply_settings(1'b1, 8'd255, 8'd255, 20'hFFFFF, 20'd25);
    random_run(270);
    drain();
    apply_settings(1'b1, 8'd100, 8'd40, 20'd1, 20'hFFFFF);
    random_run(270);
    drain();
    apply_settings(1'b0, SPD_W'($urandom), SPD_W'($urandom), 20'd10, 20'd15);
    random_run(200);
    drain();
    apply_settings(1'b1, 8'd0, 8'd0, 20'd0, 20'd1);
    random_run(270);
    drain();
    apply_settings(1'b1, SPD_W'($urandom), SPD_W'($urandom),
                   MS_W'($urandom_range(1, 40)), MS_W'($urandom_range(1, 40)));
    random_run(330);
    drain();
    repeat (10) @(posedge clk);

    $display("%0d status beats checked across %0d register settings", n_checked, n_settings);
    $display("%0d starts taken, %0d timed out by the countdown", n_started, n_autostops);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
